### design/text_frame_buffer_renderer_core_assert.svh
// Assertion macros shared by the text frame buffer renderer modules.
`ifndef TEXT_FRAME_BUFFER_RENDERER_CORE_ASSERT_SVH
`define TEXT_FRAME_BUFFER_RENDERER_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define TFBR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define TFBR_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TFBR_ASSERT(name, clk, rst, prop, msg)
`define TFBR_ASSERT_RST(name, clk, prop, msg)
`endif

`endif

### design/tfbr_pkg.sv
// Types, codes and font table shared by the text frame buffer renderer.
package tfbr_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_CURSOR  = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_REFRESH = 2'd3;

  // Field widths
  localparam int CURSOR_X_W = 8;
  localparam int CURSOR_Y_W = 3;
  localparam int PAGE_W     = 3;
  localparam int GLYPH_W    = 6;

  // Font geometry
  localparam int GLYPH_COLS   = 5;
  localparam int CHAR_ADVANCE = 6;

  // Display command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Back-end operations
  typedef logic [2:0] op_t;
  localparam op_t OP_CURSOR  = 3'd0;
  localparam op_t OP_GLYPH   = 3'd1;
  localparam op_t OP_SPACE   = 3'd2;
  localparam op_t OP_CLEAR   = 3'd3;
  localparam op_t OP_REFRESH = 3'd4;

  // Classified item handed from front to back
  typedef struct packed {
    op_t                   op;
    logic [GLYPH_W-1:0]    glyph;
    logic [CURSOR_X_W-1:0] x;
    logic [CURSOR_Y_W-1:0] y;
    logic [PAGE_W-1:0]     page;
  } cmd_t;

  // Font column lookup: first column sits in the top byte of each row
  function automatic logic [7:0] glyph_column(input logic [GLYPH_W-1:0] idx,
                                              input logic [2:0] col);
    logic [39:0] row;
    row = '0;
    case (idx)
      6'd0:  row = 40'h2054545478;
      6'd1:  row = 40'h7F48444438;
      6'd2:  row = 40'h3844444420;
      6'd3:  row = 40'h384444487F;
      6'd4:  row = 40'h3854545418;
      6'd5:  row = 40'h087E090102;
      6'd6:  row = 40'h0C5252523E;
      6'd7:  row = 40'h7F08040478;
      6'd8:  row = 40'h00447D4000;
      6'd9:  row = 40'h2040443D00;
      6'd10: row = 40'h7F10284400;
      6'd11: row = 40'h00417F4000;
      6'd12: row = 40'h7C04180478;
      6'd13: row = 40'h7C08040478;
      6'd14: row = 40'h3844444438;
      6'd15: row = 40'h7C14141408;
      6'd16: row = 40'h081414187C;
      6'd17: row = 40'h7C08040408;
      6'd18: row = 40'h4854545420;
      6'd19: row = 40'h043F444020;
      6'd20: row = 40'h3C4040207C;
      6'd21: row = 40'h1C2040201C;
      6'd22: row = 40'h3C4030403C;
      6'd23: row = 40'h4428102844;
      6'd24: row = 40'h0C5050503C;
      6'd25: row = 40'h4464544C44;
      6'd26: row = 40'h3E5149453E;
      6'd27: row = 40'h00427F4000;
      6'd28: row = 40'h4261514946;
      6'd29: row = 40'h2141454B31;
      6'd30: row = 40'h1814127F10;
      6'd31: row = 40'h2745454539;
      6'd32: row = 40'h3C4A494930;
      6'd33: row = 40'h0171090503;
      6'd34: row = 40'h3649494936;
      6'd35: row = 40'h064949291E;
      6'd36: row = 40'h0060600000;
      6'd37: row = 40'h0080600000;
      6'd38: row = 40'h0008080800;
      default: row = '0;
    endcase
    if (int'(col) >= GLYPH_COLS) begin
      return 8'h00;
    end
    return row[39 - 8 * int'(col) -: 8];
  endfunction

endpackage

### design/tfbr_ram.sv
// Generic simple dual-port RAM with registered read.
module tfbr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/tfbr_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
`include "text_frame_buffer_renderer_core_assert.svh"

module tfbr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      char_code,
  input  logic [tfbr_pkg::CURSOR_X_W-1:0] cursor_x,
  input  logic [tfbr_pkg::CURSOR_Y_W-1:0] cursor_y,
  input  logic [tfbr_pkg::PAGE_W-1:0]     page,
  output logic                            cmd_valid,
  output tfbr_pkg::cmd_t                  cmd,
  input  logic                            cmd_pop
);
  import tfbr_pkg::*;

  // Queue depth, a power of two so the pointers wrap on their own
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             q [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  cmd_t             item_cmd;
  logic             keep;
  logic             push;
  logic             pop;

  // Classify the incoming item; unsupported characters are dropped here
  always_comb begin
    item_cmd       = '0;
    item_cmd.x     = cursor_x;
    item_cmd.y     = cursor_y;
    item_cmd.page  = page;
    keep           = 1'b1;
    unique case (kind)
      KIND_CURSOR:  item_cmd.op = OP_CURSOR;
      KIND_CLEAR:   item_cmd.op = OP_CLEAR;
      KIND_REFRESH: item_cmd.op = OP_REFRESH;
      KIND_CHAR: begin
        item_cmd.op = OP_GLYPH;
        case (char_code) inside
          [8'h61:8'h7A]: item_cmd.glyph = GLYPH_W'(char_code - 8'h61);
          [8'h30:8'h39]: item_cmd.glyph = GLYPH_W'(char_code - 8'h30 + 8'd26);
          8'h2E:         item_cmd.glyph = GLYPH_W'(36);
          8'h2C:         item_cmd.glyph = GLYPH_W'(37);
          8'h2D:         item_cmd.glyph = GLYPH_W'(38);
          8'h20:         item_cmd.op    = OP_SPACE;
          default:       keep           = 1'b0;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  assign item_ready = (count != (PTR_W + 1)'(DEPTH));
  assign push       = item_valid && item_ready && keep;
  assign pop        = cmd_pop && cmd_valid;
  assign cmd_valid  = (count != '0);
  assign cmd        = q[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TFBR_ASSERT(a_queue_bound, clk, rst, count <= (PTR_W + 1)'(DEPTH), "queue overfilled")
  `TFBR_ASSERT(a_queue_push, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue push lost")

endmodule

### design/tfbr_back.sv
// Back end: cursor, frame store, clearing sweep, glyph writer and refresh sequencer.
`include "text_frame_buffer_renderer_core_assert.svh"

module tfbr_back #(
  parameter int PAGE_COLUMNS = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  tfbr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           result_valid,
  input  logic           result_ready,
  output logic           is_data,
  output logic [7:0]     command_byte,
  output logic [63:0]    data_word,
  output logic           last
);
  import tfbr_pkg::*;

  localparam int STORE_SIZE = PAGE_COLUMNS * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int WORDS      = (PAGE_COLUMNS + 7) / 8;
  localparam int COL_W      = $clog2(WORDS * 8);
  localparam int WIDE_W     = $clog2((2 ** PAGE_W) * PAGE_COLUMNS + (2 ** CURSOR_X_W));

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_GLYPH = 3'd2;
  localparam logic [2:0] S_CMD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  logic [2:0]            state,     state_next;
  logic [ADDR_W-1:0]     clr_addr,  clr_addr_next;
  logic [CURSOR_X_W-1:0] col_pos,   col_pos_next;
  logic [CURSOR_Y_W-1:0] page_pos,  page_pos_next;
  logic [GLYPH_W-1:0]    glyph_sel, glyph_sel_next;
  logic [2:0]            gcol,      gcol_next;
  logic [PAGE_W-1:0]     rf_page,   rf_page_next;
  logic [1:0]            cmd_idx,   cmd_idx_next;
  logic [COL_W-1:0]      rcol,      rcol_next;
  logic                  word_last, word_last_next;
  logic                  rd_pend,   rd_pend_next;
  logic                  rd_zero,   rd_zero_next;
  logic [2:0]            rd_byte,   rd_byte_next;
  logic [63:0]           word_acc;

  logic                  out_free;
  logic                  load_out;
  logic                  out_is_data;
  logic [7:0]            out_cmd;
  logic                  out_last;
  logic                  take;

  logic [WIDE_W-1:0]     wr_addr_wide;
  logic [WIDE_W-1:0]     rd_addr_wide;
  logic                  wr_in_range;
  logic                  rd_zero_now;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [7:0]            ram_rdata;

  // Frame store
  tfbr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr_wide[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Cursor and refresh addresses
  assign wr_addr_wide = WIDE_W'(col_pos) + WIDE_W'(page_pos) * WIDE_W'(PAGE_COLUMNS);
  assign rd_addr_wide = WIDE_W'(rf_page) * WIDE_W'(PAGE_COLUMNS) + WIDE_W'(rcol);
  assign wr_in_range  = int'(wr_addr_wide) < STORE_SIZE;
  assign rd_zero_now  = (int'(rcol) >= PAGE_COLUMNS) || (int'(rf_page) >= PAGE_COUNT);
  assign out_free     = !result_valid || result_ready;

  // Drive the write port: clearing sweep or glyph column
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_wide[ADDR_W-1:0];
    ram_wdata = glyph_column(glyph_sel, gcol);
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else if (state == S_GLYPH) begin
      ram_we    = wr_in_range;
    end
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    col_pos_next   = col_pos;
    page_pos_next  = page_pos;
    glyph_sel_next = glyph_sel;
    gcol_next      = gcol;
    rf_page_next   = rf_page;
    cmd_idx_next   = cmd_idx;
    rcol_next      = rcol;
    word_last_next = word_last;
    rd_pend_next   = 1'b0;
    rd_zero_next   = rd_zero;
    rd_byte_next   = rd_byte;
    ram_re         = 1'b0;
    load_out       = 1'b0;
    out_is_data    = 1'b0;
    out_cmd        = CMD_COL_LOW;
    out_last       = 1'b0;
    take           = 1'b0;
    cmd_pop        = 1'b0;

    unique case (state)
      S_CLEAR: begin
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
          clr_addr_next = '0;
          state_next    = S_IDLE;
        end
      end
      S_IDLE: take = 1'b1;
      S_GLYPH: begin
        col_pos_next = col_pos + 1'b1;
        gcol_next    = gcol + 1'b1;
        if (gcol == 3'(CHAR_ADVANCE - 1)) begin
          state_next = S_IDLE;
          take       = 1'b1;
        end
      end
      S_CMD: begin
        if (out_free) begin
          load_out     = 1'b1;
          cmd_idx_next = cmd_idx + 1'b1;
          case (cmd_idx)
            2'd0:    out_cmd = CMD_PAGE_BASE + 8'(rf_page);
            2'd1:    out_cmd = CMD_COL_LOW;
            default: out_cmd = CMD_COL_HIGH;
          endcase
          if (cmd_idx == 2'd2) begin
            rcol_next  = '0;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re       = !rd_zero_now;
        rd_pend_next = 1'b1;
        rd_zero_next = rd_zero_now;
        rd_byte_next = rcol[2:0];
        rcol_next    = rcol + 1'b1;
        if (rcol[2:0] == 3'd7) begin
          word_last_next = (rcol[COL_W-1:3] == (COL_W - 3)'(WORDS - 1));
          state_next     = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free && !rd_pend) begin
          load_out    = 1'b1;
          out_is_data = 1'b1;
          out_last    = word_last;
          state_next  = word_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Dispatch the next queued command from the advanced cursor
    if (take && cmd_valid) begin
      cmd_pop = 1'b1;
      case (cmd.op)
        OP_CURSOR: begin
          col_pos_next  = cmd.x;
          page_pos_next = cmd.y;
        end
        OP_SPACE: col_pos_next = col_pos_next + CURSOR_X_W'(CHAR_ADVANCE);
        OP_GLYPH: begin
          glyph_sel_next = cmd.glyph;
          gcol_next      = '0;
          state_next     = S_GLYPH;
        end
        OP_CLEAR: begin
          clr_addr_next = '0;
          state_next    = S_CLEAR;
        end
        OP_REFRESH: begin
          rf_page_next = cmd.page;
          cmd_idx_next = '0;
          state_next   = S_CMD;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      col_pos  <= '0;
      page_pos <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      col_pos  <= col_pos_next;
      page_pos <= page_pos_next;
      rd_pend  <= rd_pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    glyph_sel <= glyph_sel_next;
    gcol      <= gcol_next;
    rf_page   <= rf_page_next;
    cmd_idx   <= cmd_idx_next;
    rcol      <= rcol_next;
    word_last <= word_last_next;
    rd_zero   <= rd_zero_next;
    rd_byte   <= rd_byte_next;
    if (rd_pend) begin
      word_acc[8 * rd_byte +: 8] <= rd_zero ? 8'h00 : ram_rdata;
    end
  end

  // Output register: hold until transfer, reload when free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      is_data      <= out_is_data;
      command_byte <= out_is_data ? 8'h00 : out_cmd;
      data_word    <= out_is_data ? word_acc : 64'd0;
      last         <= out_last;
    end
  end

  `TFBR_ASSERT(a_no_write_refresh, clk, rst, (state == S_CMD || state == S_READ || state == S_PUSH) |-> !ram_we, "store written during refresh")
  `TFBR_ASSERT(a_no_pop_busy, clk, rst, (state == S_CLEAR || state == S_CMD || state == S_READ || state == S_PUSH) |-> !cmd_pop, "command taken while busy")
  `TFBR_ASSERT(a_last_is_data, clk, rst, (result_valid && last) |-> is_data, "last flag on a command result")
  `TFBR_ASSERT_RST(a_reset_clears, clk, rst |=> (state == S_CLEAR && clr_addr == '0 && !result_valid), "reset did not start clearing")

endmodule

### design/text_frame_buffer_renderer_core.sv
// Text frame buffer renderer: 5x7 character generator over a paged frame store.
//
// Input channel (item_valid/item_ready) takes one item per transfer: set cursor,
// write character, clear store or refresh one page. Items enter a four-entry
// queue, so the input keeps accepting until it is full while the back end works
// or the output waits. Output channel (result_valid/result_ready) carries the
// results of a refresh from an output register.
// Ignored codes are dropped at the front and never reach the back end. A drawn
// character writes six bytes, five font columns and a blank one, one byte per
// cycle through the single frame store write port; a clear writes zero to
// PAGE_COLUMNS*PAGE_COUNT bytes, one byte per cycle. A refresh sends three
// command bytes, then each 8-byte data word from eight byte reads on the store
// read port, then the load.
// When a refresh leaves the queue, the back end enters its command state and
// loads the first result into the output register once that register is free.
// When the receiver stalls, the result holds and the back end waits. Reset
// clears the cursor and runs a clearing pass over all PAGE_COLUMNS*PAGE_COUNT
// bytes (1024 at the defaults); queued items are not carried out before it ends.
module text_frame_buffer_renderer_core #(
  parameter int PAGE_COLUMNS = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      char_code,
  input  logic [tfbr_pkg::CURSOR_X_W-1:0] cursor_x,
  input  logic [tfbr_pkg::CURSOR_Y_W-1:0] cursor_y,
  input  logic [tfbr_pkg::PAGE_W-1:0]     page,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            is_data,
  output logic [7:0]                      command_byte,
  output logic [63:0]                     data_word,
  output logic                            last
);
  import tfbr_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Accept and classify
  tfbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .char_code  (char_code),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .page       (page),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // Execute against the frame store
  tfbr_back #(
    .PAGE_COLUMNS (PAGE_COLUMNS),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_data      (is_data),
    .command_byte (command_byte),
    .data_word    (data_word),
    .last         (last)
  );

endmodule

### tb/text_frame_buffer_renderer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text frame buffer renderer core.
module text_frame_buffer_renderer_core_tb;
  import tfbr_pkg::*;

  localparam int COLS           = 128;
  localparam int PAGES          = 8;
  localparam int STORE_BYTES    = COLS * PAGES;
  localparam int WORDS_PER_PAGE = COLS / 8;
  localparam int DIRECTED_ROWS  = 27;
  localparam int RANDOM_ITEMS   = 412;
  localparam int STEADY_FIRST   = 160;
  localparam int STEADY_END     = 280;
  localparam int STALL_LIMIT    = 10000;
  localparam int QUIET_CYCLES   = 400;
  localparam int IDLE_PERCENT   = 32;

  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] LOW_CMD    = 8'h00;
  localparam logic [7:0] HIGH_CMD   = 8'h10;
  localparam logic [7:0] SPACE_CODE = 8'h20;

  // One output transfer as the display link sees it
  typedef struct packed {
    logic        is_data;
    logic [7:0]  cmd;
    logic [63:0] word;
    logic        fin;
  } xfer_t;

  // One input item; blank marks a refresh whose page must read all zero
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [7:0] x;
    logic [2:0] y;
    logic [2:0] pg;
    logic       blank;
  } step_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  logic [1:0]  kind         = KIND_CURSOR;
  logic [7:0]  char_code    = 8'h00;
  logic [7:0]  cursor_x     = 8'h00;
  logic [2:0]  cursor_y     = 3'd0;
  logic [2:0]  page         = 3'd0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        is_data;
  logic [7:0]  command_byte;
  logic [63:0] data_word;
  logic        last;

  // Predictor state: frame image and text cursor
  logic [7:0]  store_img [0:STORE_BYTES-1];
  logic [7:0]  cur_col  = 8'h00;
  logic [2:0]  cur_page = 3'd0;

  xfer_t       pending_xfers [$];
  step_t       plan [0:DIRECTED_ROWS-1];
  bit          steady = 1'b0;
  int          errors = 0;
  int          idle_cycles = 0;

  text_frame_buffer_renderer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .char_code    (char_code),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .page         (page),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_data      (is_data),
    .command_byte (command_byte),
    .data_word    (data_word),
    .last         (last)
  );

  always #6 clk = ~clk;

  // Font columns, column 0 in element 0
  function automatic logic [0:4][7:0] font_glyph(input int slot);
    case (slot)
      0:  return 40'h20_54_54_54_78;
      1:  return 40'h7F_48_44_44_38;
      2:  return 40'h38_44_44_44_20;
      3:  return 40'h38_44_44_48_7F;
      4:  return 40'h38_54_54_54_18;
      5:  return 40'h08_7E_09_01_02;
      6:  return 40'h0C_52_52_52_3E;
      7:  return 40'h7F_08_04_04_78;
      8:  return 40'h00_44_7D_40_00;
      9:  return 40'h20_40_44_3D_00;
      10: return 40'h7F_10_28_44_00;
      11: return 40'h00_41_7F_40_00;
      12: return 40'h7C_04_18_04_78;
      13: return 40'h7C_08_04_04_78;
      14: return 40'h38_44_44_44_38;
      15: return 40'h7C_14_14_14_08;
      16: return 40'h08_14_14_18_7C;
      17: return 40'h7C_08_04_04_08;
      18: return 40'h48_54_54_54_20;
      19: return 40'h04_3F_44_40_20;
      20: return 40'h3C_40_40_20_7C;
      21: return 40'h1C_20_40_20_1C;
      22: return 40'h3C_40_30_40_3C;
      23: return 40'h44_28_10_28_44;
      24: return 40'h0C_50_50_50_3C;
      25: return 40'h44_64_54_4C_44;
      26: return 40'h3E_51_49_45_3E;
      27: return 40'h00_42_7F_40_00;
      28: return 40'h42_61_51_49_46;
      29: return 40'h21_41_45_4B_31;
      30: return 40'h18_14_12_7F_10;
      31: return 40'h27_45_45_45_39;
      32: return 40'h3C_4A_49_49_30;
      33: return 40'h01_71_09_05_03;
      34: return 40'h36_49_49_49_36;
      35: return 40'h06_49_49_29_1E;
      36: return 40'h00_60_60_00_00;
      37: return 40'h00_80_60_00_00;
      38: return 40'h00_08_08_08_00;
      default: return '0;
    endcase
  endfunction

  // Map a character code to its font slot, -1 when it has no glyph
  function automatic int glyph_slot(input logic [7:0] code);
    if (code >= "a" && code <= "z") return int'(code) - int'("a");
    if (code >= "0" && code <= "9") return 26 + int'(code) - int'("0");
    if (code == ".") return 36;
    if (code == ",") return 37;
    if (code == "-") return 38;
    return -1;
  endfunction

  // Inverse of glyph_slot for drawable characters
  function automatic logic [7:0] glyph_code(input int slot);
    if (slot < 26) return 8'("a" + slot);
    if (slot < 36) return 8'("0" + slot - 26);
    if (slot == 36) return ".";
    if (slot == 37) return ",";
    return "-";
  endfunction

  function automatic bit is_ignored(input step_t s);
    return s.kind == KIND_CHAR && glyph_slot(s.code) < 0 && s.code != SPACE_CODE;
  endfunction

  // Advance the predicted frame image and queue the transfers an item causes
  task automatic render_item(input step_t s);
    int          slot;
    int          addr;
    logic [0:4][7:0] cols;
    logic [7:0]  pix;
    xfer_t       x;
    case (s.kind)
      KIND_CURSOR: begin
        cur_col  = s.x;
        cur_page = s.y;
      end
      KIND_CHAR: begin
        slot = glyph_slot(s.code);
        if (slot >= 0) begin
          cols = font_glyph(slot);
          for (int i = 0; i < 6; i++) begin
            pix  = (i < 5) ? cols[i] : 8'h00;
            addr = int'(cur_col) + int'(cur_page) * COLS;
            // drop bytes that fall past the end of the store
            if (addr < STORE_BYTES) store_img[addr] = pix;
            cur_col = cur_col + 8'd1;
          end
        end else if (s.code == SPACE_CODE) begin
          cur_col = cur_col + 8'd6;
        end
      end
      KIND_CLEAR: begin
        for (int a = 0; a < STORE_BYTES; a++) store_img[a] = 8'h00;
      end
      default: begin
        x = '0;
        x.cmd = PAGE_CMD + {5'd0, s.pg};
        pending_xfers.push_back(x);
        x.cmd = LOW_CMD;
        pending_xfers.push_back(x);
        x.cmd = HIGH_CMD;
        pending_xfers.push_back(x);
        x.is_data = 1'b1;
        x.cmd     = 8'h00;
        for (int w = 0; w < WORDS_PER_PAGE; w++) begin
          x.word = '0;
          if (!s.blank) begin
            for (int b = 0; b < 8; b++) begin
              x.word[8*b +: 8] = store_img[int'(s.pg) * COLS + w * 8 + b];
            end
          end
          x.fin = (w == WORDS_PER_PAGE - 1);
          pending_xfers.push_back(x);
        end
      end
    endcase
  endtask

  // Drive one item, holding it until the transfer, then predict it
  task automatic send_item(input step_t s);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= s.kind;
    char_code  <= s.code;
    cursor_x   <= s.x;
    cursor_y   <= s.y;
    page       <= s.pg;
    do @(posedge clk); while (!item_ready);
    render_item(s);
  endtask

  // Random item: mostly drawable text, with cursor moves, refreshes and rare clears
  function automatic step_t random_item();
    step_t s;
    int    r;
    s.kind  = KIND_CHAR;
    s.code  = 8'($urandom_range(0, 255));
    s.x     = 8'($urandom_range(0, 255));
    s.y     = 3'($urandom_range(0, 7));
    s.pg    = 3'($urandom_range(0, 7));
    s.blank = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      s.kind = KIND_REFRESH;
      if ($urandom_range(0, 2) != 0) s.pg = cur_page;
    end else if (r < 12) begin
      s.kind = KIND_CLEAR;
    end else if (r < 26) begin
      s.kind = KIND_CURSOR;
      r = $urandom_range(0, 3);
      if (r == 0) s.x = 8'($urandom_range(240, 255));
      else if (r == 1) s.x = 8'($urandom_range(0, COLS - 1));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) s.code = glyph_code($urandom_range(0, 38));
      else if (r < 86) s.code = SPACE_CODE;
    end
    return s;
  endfunction

  // Receiver: stall at random outside the steady stretch
  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    xfer_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_xfers.size() == 0) begin
        $error("unexpected result: is_data %0d command_byte %h data_word %h last %0d",
               is_data, command_byte, data_word, last);
        errors++;
      end else begin
        want = pending_xfers.pop_front();
        if (is_data !== want.is_data) begin
          $error("is_data: expected %0d, got %0d", want.is_data, is_data);
          errors++;
        end
        if (command_byte !== want.cmd) begin
          $error("command_byte: expected %h, got %h", want.cmd, command_byte);
          errors++;
        end
        if (data_word !== want.word) begin
          $error("data_word: expected %h, got %h", want.word, data_word);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    step_t s;
    int    handled;
    for (int a = 0; a < STORE_BYTES; a++) store_img[a] = 8'h00;
    // kind, code, x, y, page, blank
    plan = '{
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd0, 1'b1},  // store is zero after reset
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd7, 1'b1},
      '{KIND_CHAR,    "a",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    "z",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    "0",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    "9",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    ".",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    ",",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    "-",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    " ",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    "A",   8'd0,   3'd0, 3'd0, 1'b0},  // no glyph: ignored
      '{KIND_CHAR,    8'hFF, 8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CURSOR,  8'h00, 8'd255, 3'd7, 3'd0, 1'b0},  // column wraps mid glyph
      '{KIND_CHAR,    "m",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CURSOR,  8'h00, 8'd200, 3'd7, 3'd0, 1'b0},  // past end of store
      '{KIND_CHAR,    "w",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd7, 1'b0},
      '{KIND_CURSOR,  8'h00, 8'd125, 3'd3, 3'd0, 1'b0},  // glyph spills into next page
      '{KIND_CHAR,    "k",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CURSOR,  8'h00, 8'd253, 3'd5, 3'd0, 1'b0},  // space wraps the column
      '{KIND_CHAR,    " ",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_CHAR,    "q",   8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd4, 1'b0},
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd5, 1'b0},
      '{KIND_CLEAR,   8'h00, 8'd0,   3'd0, 3'd0, 1'b0},
      '{KIND_REFRESH, 8'h00, 8'd0,   3'd0, 3'd4, 1'b1}   // cleared page reads zero
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i]);

    // Random part; ignored codes do not count
    handled = 0;
    while (handled < RANDOM_ITEMS) begin
      steady = (handled >= STEADY_FIRST && handled < STEADY_END);
      s = random_item();
      send_item(s);
      if (!is_ignored(s)) handled++;
    end
    steady = 1'b0;

    // Close with a refresh so all queued work is done by its last transfer
    s      = '0;
    s.kind = KIND_REFRESH;
    s.pg   = cur_page;
    send_item(s);
    item_valid <= 1'b0;

    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
